@@ rtl/core/cbsm_pkg.sv @@
// Shared types and constants for the cartridge bank-switch mapper.
// Used by cbsm_decode and cartridge_bank_switch_mapper_core; no dependencies.
package cbsm_pkg;

	localparam int ROM_ADDR_BITS_DEF = 20;
	localparam int ROM_OFF_W         = 20;
	localparam int RAM_OFF_W         = 14;
	localparam int ROM_SIZE_W        = 21;
	localparam int BANK_W            = 5;
	localparam int APB_ADDR_W        = 4;
	localparam int APB_DATA_W        = 32;

	typedef enum logic [2:0] {
		CART_NORMAL    = 3'd0,
		CART_SUPER     = 3'd1,
		CART_LARGE     = 3'd2,
		CART_SUPER_RAM = 3'd3,
		CART_SUPER_ROM = 3'd4,
		CART_ABSOLUTE  = 3'd5,
		CART_SPLIT8K   = 3'd6
	} cart_type_t;

	localparam logic [1:0] TGT_NONE = 2'd0;
	localparam logic [1:0] TGT_ROM  = 2'd1;
	localparam logic [1:0] TGT_RAM  = 2'd2;

	localparam logic [1:0] REG_CART_TYPE = 2'd0;
	localparam logic [1:0] REG_ROM_SIZE  = 2'd1;
	localparam logic [1:0] REG_SOUND     = 2'd2;

	typedef struct packed {
		logic [2:0]            cart_type;
		logic [ROM_SIZE_W-1:0] rom_size;
		logic                  sound_present;
	} cbsm_cfg_t;

	typedef struct packed {
		logic [BANK_W-1:0] bank;
		logic              loaded;
	} cbsm_state_t;

	typedef struct packed {
		logic [1:0]           target;
		logic [ROM_OFF_W-1:0] rom_offset;
		logic [RAM_OFF_W-1:0] ram_offset;
		logic                 sound_write;
		logic [3:0]           sound_reg;
		logic                 bank_switched;
		logic [BANK_W-1:0]    current_bank;
	} cbsm_result_t;

endpackage

@@ rtl/core/cartridge_bank_switch_mapper_core.sv @@
// Top level of the cartridge bank-switch mapper: register port, pipeline, bank state.
// Depends on cbsm_pkg and cbsm_decode.
//
// Usage:
// The input channel (in_valid / in_ready) carries one CPU bus request: cmd, bus_address
// and write_data. The output channel (out_valid / out_ready) returns one result per
// request, in order: target, rom_offset, ram_offset, sound_write, sound_reg,
// bank_switched and current_bank.
// A request is captured into an input register on acceptance. When the decode stage
// advances, it reads the bank register, applies any bank select carried by the write,
// decodes the address against the updated bank, and loads the result register, which
// then drives the output channel. Throughput is one request per cycle while the
// receiver takes results. The limit is the single read-modify-write of the bank
// register in the decode stage.
// When the receiver stalls, the result register holds its value and the input register
// can still take one more request; in_ready drops only when both are full.
// The APB port sets cart_type (0x0), rom_size (0x4) and sound_chip_present (0x8); it
// is to be written only while no request is in flight. pready is always high.
// Reset clears the configuration registers, the bank register and the window-loaded
// flag, and empties both pipeline registers.
module cartridge_bank_switch_mapper_core #(
	parameter int ROM_ADDR_BITS = cbsm_pkg::ROM_ADDR_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Configuration port.
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [cbsm_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [cbsm_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [cbsm_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                 pready,
	// Request channel.
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 cmd,
	input  logic [15:0]                          bus_address,
	input  logic [7:0]                           write_data,
	// Result channel.
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [1:0]                           target,
	output logic [cbsm_pkg::ROM_OFF_W-1:0]       rom_offset,
	output logic [cbsm_pkg::RAM_OFF_W-1:0]       ram_offset,
	output logic                                 sound_write,
	output logic [3:0]                           sound_reg,
	output logic                                 bank_switched,
	output logic [cbsm_pkg::BANK_W-1:0]          current_bank
);

	// Configuration registers.
	cbsm_pkg::cbsm_cfg_t    cfg_q;
	logic                   cfg_wr;

	// Bank register and window-loaded flag.
	cbsm_pkg::cbsm_state_t  state_q;
	cbsm_pkg::cbsm_state_t  state_nxt;

	// Input register stage.
	logic                   valid_s1;
	logic                   cmd_s1;
	logic [15:0]            addr_s1;
	logic [7:0]             data_s1;

	// Result register stage.
	logic                   valid_s2;
	cbsm_pkg::cbsm_result_t res_s2;
	cbsm_pkg::cbsm_result_t res;

	logic                   in_fire;
	logic                   adv_s1;

	// The register port completes every access without wait states.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				cbsm_pkg::REG_CART_TYPE: cfg_q.cart_type     <= pwdata[2:0];
				cbsm_pkg::REG_ROM_SIZE:  cfg_q.rom_size      <= pwdata[cbsm_pkg::ROM_SIZE_W-1:0];
				cbsm_pkg::REG_SOUND:     cfg_q.sound_present <= pwdata[0];
				default:                 cfg_q               <= cfg_q;
			endcase
		end
	end

	// Reads return the stored value; the unused slot reads as zero.
	always_comb begin
		case (paddr[3:2])
			cbsm_pkg::REG_CART_TYPE: prdata = {29'd0, cfg_q.cart_type};
			cbsm_pkg::REG_ROM_SIZE:  prdata = {11'd0, cfg_q.rom_size};
			cbsm_pkg::REG_SOUND:     prdata = {31'd0, cfg_q.sound_present};
			default:                 prdata = '0;
		endcase
	end

	// The decode stage moves forward whenever the result register is free or being taken.
	assign adv_s1   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s1;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_s1  <= cmd;
			addr_s1 <= bus_address;
			data_s1 <= write_data;
		end
	end

	cbsm_decode #(
		.ROM_ADDR_BITS(ROM_ADDR_BITS)
	) u_decode (
		.cfg        (cfg_q),
		.state      (state_q),
		.cmd        (cmd_s1),
		.bus_address(addr_s1),
		.write_data (data_s1),
		.state_nxt  (state_nxt),
		.result     (res)
	);

	// Bank state is committed only when a request leaves the decode stage, so
	// requests update it strictly in arrival order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res;
		end
	end

	assign out_valid     = valid_s2;
	assign target        = res_s2.target;
	assign rom_offset    = res_s2.rom_offset;
	assign ram_offset    = res_s2.ram_offset;
	assign sound_write   = res_s2.sound_write;
	assign sound_reg     = res_s2.sound_reg;
	assign bank_switched = res_s2.bank_switched;
	assign current_bank  = res_s2.current_bank;

`ifndef SYNTHESIS
	// The reported bank of a fresh result matches the committed bank register.
	a_bank_matches: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> (state_q.bank == res_s2.current_bank))
		else $error("current_bank differs from committed bank register");

	// Bank state changes only when a request leaves the decode stage.
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> ($stable(state_q.bank) && $stable(state_q.loaded)))
		else $error("bank state changed without a request");

	// Back-pressure reaches the input only when both stages are full.
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && valid_s2 && !out_ready))
		else $error("in_ready low with free pipeline space");

	// A switched bank always marks the window as loaded.
	a_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && res.bank_switched) |=> state_q.loaded)
		else $error("bank switch did not load the window");
`endif

endmodule

@@ rtl/core/cbsm_decode.sv @@
// Single-pass decode of one bus request: bank select, window decode, sound flag.
// Combinational only; depends on cbsm_pkg.
module cbsm_decode #(
	parameter int ROM_ADDR_BITS = cbsm_pkg::ROM_ADDR_BITS_DEF
) (
	input  cbsm_pkg::cbsm_cfg_t    cfg,
	input  cbsm_pkg::cbsm_state_t  state,
	input  logic                   cmd,
	input  logic [15:0]            bus_address,
	input  logic [7:0]             write_data,
	output cbsm_pkg::cbsm_state_t  state_nxt,
	output cbsm_pkg::cbsm_result_t result
);

	localparam int OFF_BITS = (ROM_ADDR_BITS < cbsm_pkg::ROM_OFF_W) ?
		ROM_ADDR_BITS : cbsm_pkg::ROM_OFF_W;
	localparam logic [cbsm_pkg::ROM_OFF_W-1:0] OFF_MASK =
		cbsm_pkg::ROM_OFF_W'((64'd1 << OFF_BITS) - 64'd1);

	cbsm_pkg::cart_type_t              ct;
	logic                              req;
	logic [cbsm_pkg::BANK_W-1:0]       bank;
	logic                              bank_ok;
	logic                              switched;
	logic                              fits7;
	logic                              fits8;
	logic                              fits_split;
	logic [15:0]                       win_base;
	logic [15:0]                       win_off;
	logic                              in_win;
	logic                              win_valid;
	logic [21:0]                       norm_sum;
	logic [1:0]                        tgt;
	logic [cbsm_pkg::ROM_OFF_W-1:0]    rom;
	logic [cbsm_pkg::RAM_OFF_W-1:0]    ram;
	logic                              snd;

	assign ct = cbsm_pkg::cart_type_t'(cfg.cart_type);

	assign fits7      = 21'd114688 < cfg.rom_size;
	assign fits8      = 21'd131072 < cfg.rom_size;
	assign fits_split = 21'd122880 < cfg.rom_size;

	// Bank select request decoded from the write, then checked against the image size.
	always_comb begin
		req  = 1'b0;
		bank = '0;
		if (cmd) begin
			case (ct)
				cbsm_pkg::CART_SUPER, cbsm_pkg::CART_SUPER_RAM, cbsm_pkg::CART_SUPER_ROM: begin
					if (bus_address >= 16'h8000 && bus_address < 16'hC000 && write_data < 8'd9) begin
						req  = 1'b1;
						bank = write_data[4:0];
					end
				end
				cbsm_pkg::CART_LARGE: begin
					if (bus_address >= 16'h8000 && bus_address < 16'hC000 && write_data < 8'd9) begin
						req  = 1'b1;
						bank = write_data[4:0] + 5'd1;
					end
				end
				cbsm_pkg::CART_ABSOLUTE: begin
					if (bus_address == 16'h8000 && (write_data == 8'd1 || write_data == 8'd2)) begin
						req  = 1'b1;
						bank = write_data[4:0] - 5'd1;
					end
				end
				cbsm_pkg::CART_SPLIT8K: begin
					if (bus_address >= 16'hFF80) begin
						req  = 1'b1;
						bank = {2'b00, bus_address[2:0]};
					end
				end
				default: begin
					req  = 1'b0;
					bank = '0;
				end
			endcase
		end
	end

	assign bank_ok   = {2'b00, bank, 14'd0} < cfg.rom_size;
	assign switched  = req && bank_ok;
	assign state_nxt.bank   = switched ? bank : state.bank;
	assign state_nxt.loaded = state.loaded | switched;

	assign snd = cmd && cfg.sound_present && bus_address >= 16'h4000 && bus_address < 16'h4009;

	// Switched window position and validity; the decode sees the bank after this write.
	always_comb begin
		case (ct)
			cbsm_pkg::CART_ABSOLUTE: win_base = 16'h4000;
			cbsm_pkg::CART_SPLIT8K:  win_base = 16'hA000;
			default:                 win_base = 16'h8000;
		endcase
	end

	assign win_off   = bus_address - win_base;
	assign in_win    = bus_address >= win_base && bus_address < (win_base + 16'h4000);
	assign win_valid = state_nxt.loaded || ct == cbsm_pkg::CART_ABSOLUTE ||
		(ct == cbsm_pkg::CART_SPLIT8K && fits_split);
	assign norm_sum  = {6'd0, bus_address} + {1'b0, cfg.rom_size};

	always_comb begin
		tgt = cbsm_pkg::TGT_NONE;
		rom = '0;
		ram = '0;
		if (ct == cbsm_pkg::CART_NORMAL) begin
			if (norm_sum >= 22'h010000) begin
				tgt = cbsm_pkg::TGT_ROM;
				rom = norm_sum[19:0] - 20'h10000;
			end
		end else if (cfg.cart_type <= 3'(cbsm_pkg::CART_SPLIT8K)) begin
			if (in_win) begin
				if (win_valid) begin
					tgt = cbsm_pkg::TGT_ROM;
					rom = {1'b0, state_nxt.bank, win_off[13:0]};
				end
			end else begin
				case (ct)
					cbsm_pkg::CART_SUPER, cbsm_pkg::CART_SUPER_RAM, cbsm_pkg::CART_SUPER_ROM: begin
						if (fits7) begin
							if (bus_address >= 16'hC000) begin
								tgt = cbsm_pkg::TGT_ROM;
								rom = {3'b000, 3'd7, bus_address[13:0]};
							end else if (bus_address >= 16'h4000 && bus_address < 16'h8000) begin
								if (ct == cbsm_pkg::CART_SUPER_RAM) begin
									tgt = cbsm_pkg::TGT_RAM;
									ram = bus_address[13:0];
								end else if (ct == cbsm_pkg::CART_SUPER_ROM) begin
									tgt = cbsm_pkg::TGT_ROM;
									rom = {3'b000, 3'd6, bus_address[13:0]};
								end
							end
						end
					end
					cbsm_pkg::CART_LARGE: begin
						if (fits8) begin
							if (bus_address >= 16'hC000) begin
								tgt = cbsm_pkg::TGT_ROM;
								rom = {2'b00, 4'd8, bus_address[13:0]};
							end else if (bus_address >= 16'h4000 && bus_address < 16'h8000) begin
								tgt = cbsm_pkg::TGT_ROM;
								rom = {6'd0, bus_address[13:0]};
							end
						end
					end
					cbsm_pkg::CART_ABSOLUTE: begin
						if (bus_address >= 16'h8000) begin
							tgt = cbsm_pkg::TGT_ROM;
							rom = {4'd0, bus_address};
						end
					end
					cbsm_pkg::CART_SPLIT8K: begin
						if (fits_split) begin
							if (bus_address >= 16'h4000 && bus_address < 16'h6000) begin
								tgt = cbsm_pkg::TGT_ROM;
								rom = 20'd106496 + {7'd0, bus_address[12:0]};
							end else if (bus_address >= 16'h6000 && bus_address < 16'h8000) begin
								tgt = cbsm_pkg::TGT_ROM;
								rom = 20'd98304 + {7'd0, bus_address[12:0]};
							end else if (bus_address >= 16'h8000 && bus_address < 16'hA000) begin
								tgt = cbsm_pkg::TGT_ROM;
								rom = 20'd122880 + {7'd0, bus_address[12:0]};
							end else if (bus_address >= 16'hE000) begin
								tgt = cbsm_pkg::TGT_ROM;
								rom = 20'd114688 + {7'd0, bus_address[12:0]};
							end
						end
					end
					default: begin
						tgt = cbsm_pkg::TGT_NONE;
					end
				endcase
			end
		end
	end

	assign result.target        = tgt;
	assign result.rom_offset    = rom & OFF_MASK;
	assign result.ram_offset    = ram;
	assign result.sound_write   = snd;
	assign result.sound_reg     = snd ? bus_address[3:0] : 4'd0;
	assign result.bank_switched = switched;
	assign result.current_bank  = state_nxt.bank;

endmodule

@@ dv/cartridge_bank_switch_mapper_core_tb.sv @@
// Self-checking testbench for cartridge_bank_switch_mapper_core: directed and random bus requests
// under changing cartridge settings, checked against an in-bench translation of every request.
// Depends on cbsm_pkg and the mapper RTL only.
`timescale 1ns / 1ps

module cartridge_bank_switch_mapper_core_tb;

	localparam int ROM_BITS = 20;
	localparam int unsigned BANK_BYTES = 16384;
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int PHASES = 12;
	localparam int REQUESTS_PER_PHASE = 150;
	localparam int HOLD_OFF_CYCLES = 60;
	// Extra cycles waited after the last result has been taken, as a margin.
	localparam int DRAIN_CYCLES = 6;

	localparam logic CMD_READ = 1'b0;
	localparam logic CMD_WRITE = 1'b1;
	// Type code 7 has no layout: nothing maps and no bank select is honored.
	localparam logic [2:0] CART_UNDEFINED = 3'd7;

	// Keeps its own copy of the settings and bank state, translates each accepted request
	// and holds the resulting expectations in arrival order.
	class bank_map_scoreboard;
		logic [2:0] cart;
		int unsigned rom_size;
		logic sound_on;
		int unsigned bank;
		logic loaded;
		cbsm_pkg::cbsm_result_t pending_results[$];
		int unsigned errors, n_rom, n_ram, n_none, n_loads, n_sound, n_checked;

		function new();
			cart = cbsm_pkg::CART_NORMAL;
			rom_size = 0;
			sound_on = 1'b0;
			bank = 0;
			loaded = 1'b0;
		endfunction

		function void set_register(logic [1:0] idx, logic [31:0] value);
			case (idx)
				cbsm_pkg::REG_CART_TYPE: cart = value[2:0];
				cbsm_pkg::REG_ROM_SIZE: rom_size = 32'(value[cbsm_pkg::ROM_SIZE_W-1:0]);
				cbsm_pkg::REG_SOUND: sound_on = value[0];
				default: ;
			endcase
		endfunction

		function bit fits(int unsigned b);
			return b * BANK_BYTES < rom_size;
		endfunction

		function bit window_shown();
			return loaded || cart == cbsm_pkg::CART_ABSOLUTE ||
				(cart == cbsm_pkg::CART_SPLIT8K && rom_size > 122880);
		endfunction

		function logic [1:0] translate(int unsigned a, output int unsigned rom,
				output int unsigned ram);
			int unsigned base;
			rom = 0;
			ram = 0;
			if (cart == cbsm_pkg::CART_NORMAL) begin
				// The image ends at 0xFFFF, so small images leave the low addresses unmapped.
				if (a + rom_size >= 65536) begin
					rom = a + rom_size - 65536;
					return cbsm_pkg::TGT_ROM;
				end
				return cbsm_pkg::TGT_NONE;
			end
			if (cart == CART_UNDEFINED)
				return cbsm_pkg::TGT_NONE;
			base = (cart == cbsm_pkg::CART_ABSOLUTE) ? 32'h4000 :
				(cart == cbsm_pkg::CART_SPLIT8K) ? 32'hA000 : 32'h8000;
			if (a >= base && a < base + BANK_BYTES) begin
				if (!window_shown())
					return cbsm_pkg::TGT_NONE;
				rom = bank * BANK_BYTES + (a - base);
				return cbsm_pkg::TGT_ROM;
			end
			case (cart)
				cbsm_pkg::CART_SUPER, cbsm_pkg::CART_SUPER_RAM, cbsm_pkg::CART_SUPER_ROM: begin
					if (!fits(7))
						return cbsm_pkg::TGT_NONE;
					if (a >= 32'hC000) begin
						rom = 7 * BANK_BYTES + (a - 32'hC000);
						return cbsm_pkg::TGT_ROM;
					end
					if (a >= 32'h4000 && a < 32'h8000) begin
						if (cart == cbsm_pkg::CART_SUPER_RAM) begin
							ram = a - 32'h4000;
							return cbsm_pkg::TGT_RAM;
						end
						if (cart == cbsm_pkg::CART_SUPER_ROM) begin
							rom = 6 * BANK_BYTES + (a - 32'h4000);
							return cbsm_pkg::TGT_ROM;
						end
					end
					return cbsm_pkg::TGT_NONE;
				end
				cbsm_pkg::CART_LARGE: begin
					if (!fits(8))
						return cbsm_pkg::TGT_NONE;
					if (a >= 32'hC000) begin
						rom = 8 * BANK_BYTES + (a - 32'hC000);
						return cbsm_pkg::TGT_ROM;
					end
					if (a >= 32'h4000 && a < 32'h8000) begin
						rom = a - 32'h4000;
						return cbsm_pkg::TGT_ROM;
					end
					return cbsm_pkg::TGT_NONE;
				end
				cbsm_pkg::CART_ABSOLUTE: begin
					if (a >= 32'h8000) begin
						rom = 32768 + (a - 32'h8000);
						return cbsm_pkg::TGT_ROM;
					end
					return cbsm_pkg::TGT_NONE;
				end
				default: begin
					// Four fixed 8 KiB slices around the switched window.
					if (!(rom_size > 122880))
						return cbsm_pkg::TGT_NONE;
					if (a >= 32'h4000 && a < 32'h6000) begin
						rom = 106496 + (a - 32'h4000);
						return cbsm_pkg::TGT_ROM;
					end
					if (a >= 32'h6000 && a < 32'h8000) begin
						rom = 98304 + (a - 32'h6000);
						return cbsm_pkg::TGT_ROM;
					end
					if (a >= 32'h8000 && a < 32'hA000) begin
						rom = 122880 + (a - 32'h8000);
						return cbsm_pkg::TGT_ROM;
					end
					if (a >= 32'hE000) begin
						rom = 114688 + (a - 32'hE000);
						return cbsm_pkg::TGT_ROM;
					end
					return cbsm_pkg::TGT_NONE;
				end
			endcase
		endfunction

		function void note_access(logic c, logic [15:0] addr, logic [7:0] d);
			cbsm_pkg::cbsm_result_t r;
			bit sel;
			int unsigned nb, a, rom, ram;
			r = '0;
			sel = 0;
			nb = 0;
			a = 32'(addr);
			if (c == CMD_WRITE) begin
				case (cart)
					cbsm_pkg::CART_SUPER, cbsm_pkg::CART_SUPER_RAM, cbsm_pkg::CART_SUPER_ROM:
						if (a >= 32'h8000 && a < 32'hC000 && d < 9) begin
							sel = 1;
							nb = 32'(d);
						end
					cbsm_pkg::CART_LARGE:
						if (a >= 32'h8000 && a < 32'hC000 && d < 9) begin
							sel = 1;
							nb = 32'(d) + 1;
						end
					cbsm_pkg::CART_ABSOLUTE:
						if (a == 32'h8000 && (d == 1 || d == 2)) begin
							sel = 1;
							nb = 32'(d) - 1;
						end
					cbsm_pkg::CART_SPLIT8K:
						if (a >= 32'hFF80) begin
							sel = 1;
							nb = a & 7;
						end
					default: ;
				endcase
				if (sel && fits(nb)) begin
					bank = nb & 32'h1F;
					loaded = 1'b1;
					r.bank_switched = 1'b1;
					n_loads++;
				end
				if (sound_on && a >= 32'h4000 && a < 32'h4009) begin
					r.sound_write = 1'b1;
					r.sound_reg = 4'(a - 32'h4000);
					n_sound++;
				end
			end
			r.target = translate(a, rom, ram);
			r.rom_offset = cbsm_pkg::ROM_OFF_W'(rom & ((32'd1 << ROM_BITS) - 1));
			r.ram_offset = cbsm_pkg::RAM_OFF_W'(ram);
			r.current_bank = cbsm_pkg::BANK_W'(bank);
			case (r.target)
				cbsm_pkg::TGT_ROM: n_rom++;
				cbsm_pkg::TGT_RAM: n_ram++;
				default: n_none++;
			endcase
			pending_results.push_back(r);
		endfunction

		function void compare(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_result(cbsm_pkg::cbsm_result_t got);
			cbsm_pkg::cbsm_result_t want;
			if (pending_results.size() == 0) begin
				$display("%0t: result with no request outstanding, expected none, got 0x%0h",
					$time, got);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			n_checked++;
			compare("target", 32'(want.target), 32'(got.target));
			compare("rom_offset", 32'(want.rom_offset), 32'(got.rom_offset));
			compare("ram_offset", 32'(want.ram_offset), 32'(got.ram_offset));
			compare("sound_write", 32'(want.sound_write), 32'(got.sound_write));
			compare("sound_reg", 32'(want.sound_reg), 32'(got.sound_reg));
			compare("bank_switched", 32'(want.bank_switched), 32'(got.bank_switched));
			compare("current_bank", 32'(want.current_bank), 32'(got.current_bank));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [cbsm_pkg::APB_ADDR_W-1:0] paddr = '0;
	logic [cbsm_pkg::APB_DATA_W-1:0] pwdata = '0;
	logic [cbsm_pkg::APB_DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic cmd = CMD_READ;
	logic [15:0] bus_address = '0;
	logic [7:0] write_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] target;
	logic [cbsm_pkg::ROM_OFF_W-1:0] rom_offset;
	logic [cbsm_pkg::RAM_OFF_W-1:0] ram_offset;
	logic sound_write;
	logic [3:0] sound_reg;
	logic bank_switched;
	logic [cbsm_pkg::BANK_W-1:0] current_bank;

	bank_map_scoreboard sb = new();

	// Traffic shaping. The sender percentage is only used by the stimulus process; the
	// receiver percentage and the hold-off flag are read by the receiver at each edge, so
	// they change only through nonblocking assignments.
	int send_idle_pct = 0;
	int stall_pct = 0;
	logic hold_off = 1'b0;
	int unsigned cycle_count = 0;
	int unsigned n_settings = 0;
	logic [2:0] cur_cart = cbsm_pkg::CART_NORMAL;

	// Window and slice boundaries of all layouts, plus the bank select area.
	logic [15:0] border_addr [14] = '{16'h0000, 16'h3FFF, 16'h4000, 16'h5FFF, 16'h6000,
		16'h7FFF, 16'h8000, 16'h9FFF, 16'hA000, 16'hBFFF, 16'hC000, 16'hDFFF, 16'hFF7F, 16'hFFFF};

	// Image sizes around the fit limits of banks 1, 7, 8 and 9 and of the fixed slices.
	int unsigned size_pool [12] = '{0, 16385, 32768, 65536, 114688, 114689, 122881, 131072,
		131073, 147457, 1048576, 2097151};

	cartridge_bank_switch_mapper_core #(
		.ROM_ADDR_BITS(ROM_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.bus_address(bus_address),
		.write_data(write_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.target(target),
		.rom_offset(rom_offset),
		.ram_offset(ram_offset),
		.sound_write(sound_write),
		.sound_reg(sound_reg),
		.bank_switched(bank_switched),
		.current_bank(current_bank)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog. A hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Receiver. A result is checked at the edge where it is taken; out_ready for the next
	// edge is then drawn from the current stall rate unless a long hold-off is running.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result({target, rom_offset, ram_offset, sound_write, sound_reg,
				bank_switched, current_bank});
		out_ready <= !hold_off && ($urandom_range(0, 99) >= stall_pct);
	end

	// Offers one request and returns at the edge where the block takes it. The request is
	// noted at that same edge, well before its result can come back.
	task automatic send_request(input logic c, input logic [15:0] a, input logic [7:0] d);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		bus_address <= a;
		write_data <= d;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_access(c, a, d);
	endtask

	// Waits until every request has returned its result, then waits out the drain margin. The
	// first step always advances time so a result taken at this edge is seen as gone.
	task automatic wait_idle();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Setup cycle, then access cycle; the register takes the value at the access edge.
	task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_register(idx, value);
		if (idx == cbsm_pkg::REG_CART_TYPE)
			cur_cart = value[2:0];
	endtask

	// New settings are only written once the pipeline has drained.
	task automatic apply_settings(input logic [2:0] cart, input int unsigned size,
			input logic sound);
		wait_idle();
		write_register(cbsm_pkg::REG_CART_TYPE, {29'd0, cart});
		write_register(cbsm_pkg::REG_ROM_SIZE, size);
		write_register(cbsm_pkg::REG_SOUND, {31'd0, sound});
		n_settings++;
	endtask

	task automatic set_idle_mode(input int mode);
		case (mode)
			0: begin
				send_idle_pct = 0;
				stall_pct <= 0;
			end
			1: begin
				send_idle_pct = 82;
				stall_pct <= 0;
			end
			2: begin
				send_idle_pct = 0;
				stall_pct <= 82;
			end
			default: begin
				send_idle_pct = 17;
				stall_pct <= 17;
			end
		endcase
	endtask

	// Runs in its own process: the receiver refuses results for a long stretch while the
	// sender keeps offering, so both pipeline registers fill and in_ready drops.
	task automatic hold_receiver(input int cycles_n);
		hold_off <= 1'b1;
		repeat (cycles_n) @(posedge clk);
		hold_off <= 1'b0;
	endtask

	// Half of the random requests are meaningful for the current layout: bank selects with
	// mostly valid data, sound register writes, and accesses on window boundaries.
	// The rest are reads and writes anywhere with any data.
	task automatic make_request(output logic c, output logic [15:0] a, output logic [7:0] d);
		int unsigned pick;
		pick = $urandom_range(0, 99);
		c = 1'($urandom_range(0, 1));
		a = 16'($urandom);
		d = 8'($urandom);
		if (pick < 25) begin
			c = CMD_WRITE;
			case (cur_cart)
				cbsm_pkg::CART_SUPER, cbsm_pkg::CART_SUPER_RAM, cbsm_pkg::CART_SUPER_ROM,
				cbsm_pkg::CART_LARGE: begin
					a = 16'($urandom_range(16'h8000, 16'hBFFF));
					d = 8'($urandom_range(0, 9));
				end
				cbsm_pkg::CART_ABSOLUTE: begin
					a = 16'h8000;
					d = 8'($urandom_range(0, 3));
				end
				cbsm_pkg::CART_SPLIT8K: a = 16'($urandom_range(16'hFF80, 16'hFFFF));
				default: ;
			endcase
		end else if (pick < 35) begin
			a = 16'h4000 + 16'($urandom_range(0, 9));
			c = ($urandom_range(0, 3) != 0);
		end else if (pick < 50)
			a = border_addr[$urandom_range(0, 13)];
		else if (pick < 85)
			c = CMD_READ;
	endtask

	initial begin
		logic c;
		logic [15:0] a;
		logic [7:0] d;
		int unsigned size;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, no idling. Normal layout with a 48 KiB image: the low addresses
		// are unmapped, the top byte is the last image byte, and sound writes are flagged
		// from 0x4000 through 0x4008 but not at 0x4009.
		apply_settings(cbsm_pkg::CART_NORMAL, 49152, 1'b1);
		send_request(CMD_READ, 16'h0000, 8'h00);
		send_request(CMD_READ, 16'hFFFF, 8'hFF);
		send_request(CMD_WRITE, 16'h4000, 8'hFF);
		send_request(CMD_WRITE, 16'h4008, 8'h00);
		send_request(CMD_WRITE, 16'h4009, 8'h55);

		// Supercart with eight banks. The window starts empty; data 9 is not a select;
		// selecting the held bank again still counts as a switch; bank 8 does not fit.
		apply_settings(cbsm_pkg::CART_SUPER, 131072, 1'b0);
		send_request(CMD_READ, 16'h8000, 8'h00);
		send_request(CMD_WRITE, 16'h8000, 8'h09);
		send_request(CMD_WRITE, 16'hBFFF, 8'h03);
		send_request(CMD_WRITE, 16'h8000, 8'h03);
		send_request(CMD_READ, 16'hC000, 8'h00);
		send_request(CMD_WRITE, 16'h8000, 8'h08);

		// The bank survives a type change. The RAM variant maps 0x4000..0x7FFF to RAM,
		// and a sound write there decodes to RAM as well.
		apply_settings(cbsm_pkg::CART_SUPER_RAM, 131072, 1'b1);
		send_request(CMD_READ, 16'h4000, 8'h00);
		send_request(CMD_READ, 16'h7FFF, 8'h00);
		send_request(CMD_WRITE, 16'h4003, 8'hA5);

		// Absolute layout with no image: the fixed area still maps and the window shows
		// the held bank, but no select can fit.
		apply_settings(cbsm_pkg::CART_ABSOLUTE, 0, 1'b0);
		send_request(CMD_READ, 16'hFFFF, 8'h00);
		send_request(CMD_WRITE, 16'h8000, 8'h02);
		send_request(CMD_READ, 16'h4000, 8'h00);

		// Split layout with a 1 MiB image: a select from the top page, then every slice.
		apply_settings(cbsm_pkg::CART_SPLIT8K, 1048576, 1'b0);
		send_request(CMD_WRITE, 16'hFFFF, 8'h00);
		send_request(CMD_READ, 16'h4000, 8'h00);
		send_request(CMD_READ, 16'h6000, 8'h00);
		send_request(CMD_READ, 16'h8000, 8'h00);
		send_request(CMD_READ, 16'hE000, 8'h00);

		// The undefined type maps nothing, yet still flags sound writes.
		apply_settings(CART_UNDEFINED, 1048576, 1'b1);
		send_request(CMD_WRITE, 16'h4000, 8'h00);
		send_request(CMD_READ, 16'h8000, 8'h00);

		// Random part. The type steps through all eight codes, the image size comes mostly
		// from sizes at the fit limits, and the idle mode rotates every phase. One phase
		// without idling also gets the long receiver hold-off.
		for (int phase = 0; phase < PHASES; phase++) begin
			if ($urandom_range(0, 3) == 0)
				size = $urandom_range(0, 1048576);
			else
				size = size_pool[$urandom_range(0, 11)];
			apply_settings(3'((phase * 3) % 8), size, 1'($urandom_range(0, 1)));
			set_idle_mode(phase % 4);
			if (phase == 4)
				fork
					hold_receiver(HOLD_OFF_CYCLES);
				join_none
			repeat (REQUESTS_PER_PHASE) begin
				make_request(c, a, d);
				send_request(c, a, d);
			end
		end

		wait_idle();
		$display("Checked %0d results over %0d settings: %0d ROM, %0d RAM, %0d unmapped.",
			sb.n_checked, n_settings, sb.n_rom, sb.n_ram, sb.n_none);
		$display("Requests loaded %0d banks and hit %0d sound registers.", sb.n_loads,
			sb.n_sound);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

@@ cartridge_bank_switch_mapper_core.f @@
rtl/core/cbsm_pkg.sv
rtl/core/cbsm_decode.sv
rtl/core/cartridge_bank_switch_mapper_core.sv
dv/cartridge_bank_switch_mapper_core_tb.sv
